// File: hdl/ior_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the image orientation rotator.
// No dependencies; used by image_orientation_rotator and its testbench.
package ior_pkg;

  // Widths fixed by the register and request formats
  localparam int unsigned DimW     = 7;   // size register width
  localparam int unsigned ProdW    = 14;  // DimW x DimW product
  localparam int unsigned OrientW  = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 7;
  localparam int unsigned PixW     = 32;
  localparam int unsigned OutIdxW  = 12;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegSrcWidth   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSrcHeight  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegOrientation = 2'd2;

  // Register reset values
  localparam logic [DimW-1:0]    SrcWidthRst   = 7'd64;
  localparam logic [DimW-1:0]    SrcHeightRst  = 7'd64;
  localparam logic [OrientW-1:0] OrientRst     = 4'd1;

  // Orientation codes that rotate; all others copy
  localparam logic [OrientW-1:0] OrientRot180   = 4'd3;
  localparam logic [OrientW-1:0] OrientRot90Cw  = 4'd6;
  localparam logic [OrientW-1:0] OrientRot90Ccw = 4'd8;

  // Request kinds
  localparam logic ReqWrite = 1'b0;
  localparam logic ReqRead  = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [PixW-1:0]     pixel_in;
    logic [OutIdxW-1:0]  out_index;
  } req_t;

  typedef struct packed {
    logic [PixW-1:0] pixel_out;
    logic            frame_done;
    logic            index_error;
  } rsp_t;

endpackage

// File: hdl/ior_frame_mem.sv
`timescale 1ns / 1ps
// Single-port frame buffer with a registered read port.
// No package dependencies.
module ior_frame_mem #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = 12,
  parameter int unsigned DataW = 32
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [DataW-1:0] wdata_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/image_orientation_rotator.sv
`timescale 1ns / 1ps
// Image orientation rotator top level: counters, address mapping, control.
// Depends on ior_pkg and ior_frame_mem.
//
// Each request is captured at its accepting edge. In the execute state it
// maps the source position to its rotated address (a single small
// multiply) and accesses the frame buffer; in the load state the buffer's
// registered read data goes into the response register, which waits while
// the previous response still waits on the receiver. The next request is
// taken in the cycle after the response register loads, even if that
// response is still waiting, so no new request is taken while one is in
// flight. Write requests place pixels in source raster order at their
// rotated position. Read requests return the rotated image at a linear
// index and flag indexes at or past w*h.
// Reading an entry that was never written returns undefined data.
module image_orientation_rotator #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64,
  parameter int unsigned PIXEL_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [ior_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [ior_pkg::CfgDataW-1:0]      cfg_wdata_i,
  // request channel
  input  logic                              req_valid_i,
  output logic                              req_ready_o,
  input  ior_pkg::req_t                     req_i,
  // response channel
  output logic                              rsp_valid_o,
  input  logic                              rsp_ready_i,
  output ior_pkg::rsp_t                     rsp_o
);

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned DW    = ior_pkg::DimW;
  localparam int unsigned PW    = ior_pkg::ProdW;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StExec = 2'd1;
  localparam logic [1:0] StLoad = 2'd2;

  // Configuration registers
  logic [DW-1:0]                  width_q, height_q;
  logic [ior_pkg::OrientW-1:0]    orient_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ior_pkg::SrcWidthRst;
      height_q <= ior_pkg::SrcHeightRst;
      orient_q <= ior_pkg::OrientRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ior_pkg::RegSrcWidth:    width_q  <= cfg_wdata_i;
        ior_pkg::RegSrcHeight:   height_q <= cfg_wdata_i;
        ior_pkg::RegOrientation: orient_q <= cfg_wdata_i[ior_pkg::OrientW-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size: zero reads as one, large values clamp to the max
  logic [DW-1:0] w_eff, h_eff;
  logic [PW-1:0] total;

  always_comb begin
    if (width_q == '0) begin
      w_eff = DW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = DW'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = DW'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_eff = DW'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
  end

  assign total = PW'(w_eff) * PW'(h_eff);

  // Control state and captured request
  logic [1:0]      state_q, state_d;
  ior_pkg::req_t   req_q;
  logic [CW-1:0]   col_q, col_d;
  logic [RW-1:0]   row_q, row_d;
  logic            res_read_q, res_done_q, res_err_q;
  logic            rsp_valid_q;
  ior_pkg::rsp_t   rsp_q;

  logic            accept;
  logic            exec_write, exec_read;
  logic            load;

  assign req_ready_o = (state_q == StIdle);
  assign accept      = req_valid_i && req_ready_o;
  assign exec_write  = (state_q == StExec) && (req_q.req_type == ior_pkg::ReqWrite);
  assign exec_read   = (state_q == StExec) && (req_q.req_type == ior_pkg::ReqRead);
  assign load        = (state_q == StLoad) && (!rsp_valid_q || rsp_ready_i);

  // Source position, restarted when it lies outside a shrunken frame
  logic          wrap;
  logic [DW-1:0] x, y;

  assign wrap = (32'(col_q) >= 32'(w_eff)) || (32'(row_q) >= 32'(h_eff));
  assign x    = wrap ? '0 : DW'(col_q);
  assign y    = wrap ? '0 : DW'(row_q);

  // Rotated address: one multiply plus an offset
  logic [DW-1:0] mul_a, mul_b, add_c;
  logic [PW-1:0] addr_calc;

  always_comb begin
    case (orient_q)
      ior_pkg::OrientRot180: begin
        mul_a = h_eff - DW'(1) - y;
        mul_b = w_eff;
        add_c = w_eff - DW'(1) - x;
      end
      ior_pkg::OrientRot90Cw: begin
        mul_a = x;
        mul_b = h_eff;
        add_c = h_eff - DW'(1) - y;
      end
      ior_pkg::OrientRot90Ccw: begin
        mul_a = w_eff - DW'(1) - x;
        mul_b = h_eff;
        add_c = y;
      end
      default: begin
        mul_a = y;
        mul_b = w_eff;
        add_c = x;
      end
    endcase
  end

  assign addr_calc = PW'(mul_a) * PW'(mul_b) + PW'(add_c);

  // Read index range check
  logic idx_ok;
  assign idx_ok = (PW'(req_q.out_index) < total) && (32'(req_q.out_index) < Depth);

  // Counter advance and frame completion
  logic          last_col, last_row;
  assign last_col = (PW'(x) + PW'(1)) >= PW'(w_eff);
  assign last_row = (PW'(y) + PW'(1)) >= PW'(h_eff);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (exec_write) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : RW'(y + DW'(1));
      end else begin
        col_d = CW'(x + DW'(1));
        row_d = RW'(y);
      end
    end
  end

  // Sequencer: capture, execute, load response
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (accept) state_d = StExec;
      StExec:  state_d = StLoad;
      StLoad:  if (load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  // Request payload and per-request result flags
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (state_q == StExec) begin
      res_read_q <= exec_read;
      res_done_q <= exec_write && last_col && last_row;
      res_err_q  <= exec_read && !idx_ok;
    end
  end

  // Frame buffer
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_addr;
  logic [PIXEL_BITS-1:0] mem_rdata;

  assign mem_we   = exec_write;
  assign mem_re   = exec_read && idx_ok;
  assign mem_addr = exec_read ? AW'(req_q.out_index) : AW'(addr_calc);

  ior_frame_mem #(
    .Depth (Depth),
    .AddrW (AW),
    .DataW (PIXEL_BITS)
  ) u_frame_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (PIXEL_BITS'(req_q.pixel_in)),
    .rdata_o (mem_rdata)
  );

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rsp_q.pixel_out   <= (res_read_q && !res_err_q) ? ior_pkg::PixW'(mem_rdata) : '0;
      rsp_q.frame_done  <= res_done_q;
      rsp_q.index_error <= res_err_q;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // Checks
  a_exec_then_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StExec |=> state_q == StLoad)
    else $error("execute cycle not followed by load");

  a_write_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (addr_calc < total))
    else $error("rotated write address outside frame");

  a_counters_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_write |=> (32'(col_q) < 32'(w_eff)) && (32'(row_q) < 32'(h_eff)))
    else $error("position counters left the frame");

  a_done_clears_counters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLoad) && res_done_q |-> (col_q == '0) && (row_q == '0))
    else $error("frame done without counter wrap");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !(rsp_o.frame_done && rsp_o.index_error))
    else $error("frame_done and index_error both set");

endmodule

// File: test/image_orientation_rotator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for image_orientation_rotator: directed table, then random phases.
// Depends on ior_pkg and the rotator RTL; keeps its own frame buffer model for prediction.
module image_orientation_rotator_tb;

  localparam int unsigned ClkPeriod     = 8;
  localparam int unsigned MaxW          = 64;
  localparam int unsigned MaxH          = 64;
  localparam int unsigned StoreDepth    = MaxW * MaxH;
  localparam int unsigned NumPhases     = 16;
  localparam int unsigned ItemsPerPhase = 105;
  localparam int unsigned SettleCycles  = 4;     // pipeline depth plus margin
  localparam int unsigned StuckLimit    = 2000;  // cycles with no handshake at all
  localparam int unsigned MaxReports    = 30;

  localparam ior_pkg::rsp_t RspQuiet  = '0;
  localparam ior_pkg::rsp_t RspDone   =
    '{pixel_out: 32'h0, frame_done: 1'b1, index_error: 1'b0};
  localparam ior_pkg::rsp_t RspIdxErr =
    '{pixel_out: 32'h0, frame_done: 1'b0, index_error: 1'b1};

  typedef enum logic {RowReq, RowCfg} row_kind_e;

  // One line of the directed table: a request or a full register setting
  typedef struct packed {
    row_kind_e                   kind;
    logic [ior_pkg::DimW-1:0]    w;
    logic [ior_pkg::DimW-1:0]    h;
    logic [ior_pkg::OrientW-1:0] o;
    ior_pkg::req_t               rq;
    logic                        chk;
    ior_pkg::rsp_t               want;
  } dir_row_t;

  // DUT connections
  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         cfg_we;
  logic [ior_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [ior_pkg::CfgDataW-1:0] cfg_wdata;
  logic                         req_valid;
  logic                         req_ready;
  ior_pkg::req_t                req;
  logic                         rsp_valid;
  logic                         rsp_ready;
  ior_pkg::rsp_t                rsp;

  // Rotator model state
  logic [ior_pkg::PixW-1:0]     img_mem [StoreDepth];
  bit                           img_valid [StoreDepth];
  int unsigned                  written_q [$];
  int unsigned                  col_q;
  int unsigned                  row_q;
  logic [ior_pkg::DimW-1:0]     width_reg;
  logic [ior_pkg::DimW-1:0]     height_reg;
  logic [ior_pkg::OrientW-1:0]  orient_reg;

  // Scoreboard and bookkeeping
  ior_pkg::rsp_t       due_rsp_q [$];
  ior_pkg::rsp_t       chk_want;
  dir_row_t            dir_tab [$];
  int unsigned         send_idle_pct;
  int unsigned         stall_pct;
  int unsigned         fail_cnt;
  int unsigned         stuck_cyc;
  int unsigned         n_writes;
  int unsigned         n_reads;
  int unsigned         n_frames;
  int unsigned         n_idx_err;
  int unsigned         n_settings;

  image_orientation_rotator #(
    .MAX_WIDTH  (MaxW),
    .MAX_HEIGHT (MaxH),
    .PIXEL_BITS (ior_pkg::PixW)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // Size register as the block uses it: zero means one, big values saturate
  function automatic int unsigned eff_dim(logic [ior_pkg::DimW-1:0] v, int unsigned maxv);
    if (v == '0) return 1;
    if (v > maxv) return maxv;
    return 32'(v);
  endfunction

  // Place a written pixel at its rotated address, or fetch a rotated pixel
  task automatic predict_rotated(input ior_pkg::req_t r, output ior_pkg::rsp_t e);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned y;
    int unsigned addr;
    w = eff_dim(width_reg, MaxW);
    h = eff_dim(height_reg, MaxH);
    e = '0;
    if (r.req_type == ior_pkg::ReqWrite) begin
      // size shrank under a partial frame: restart at the origin
      if (col_q >= w || row_q >= h) begin
        col_q = 0;
        row_q = 0;
      end
      x = col_q;
      y = row_q;
      case (orient_reg)
        ior_pkg::OrientRot180:   addr = (h - 1 - y) * w + (w - 1 - x);
        ior_pkg::OrientRot90Cw:  addr = x * h + (h - 1 - y);
        ior_pkg::OrientRot90Ccw: addr = (w - 1 - x) * h + y;
        default:                 addr = y * w + x;
      endcase
      img_mem[addr] = r.pixel_in;
      if (!img_valid[addr]) begin
        img_valid[addr] = 1'b1;
        written_q.push_back(addr);
      end
      if (x + 1 >= w) begin
        col_q = 0;
        if (y + 1 >= h) begin
          row_q = 0;
          e.frame_done = 1'b1;
        end else begin
          row_q = y + 1;
        end
      end else begin
        col_q = x + 1;
      end
    end else begin
      if (r.out_index < w * h) e.pixel_out = img_mem[r.out_index];
      else e.index_error = 1'b1;
    end
  endtask

  function automatic dir_row_t req_row(logic kind_rd, logic [ior_pkg::PixW-1:0] pix,
                                       logic [ior_pkg::OutIdxW-1:0] idx, logic chk,
                                       ior_pkg::rsp_t want);
    dir_row_t d;
    d = '0;
    d.kind = RowReq;
    d.rq = '{req_type: kind_rd, pixel_in: pix, out_index: idx};
    d.chk = chk;
    d.want = want;
    return d;
  endfunction

  function automatic dir_row_t cfg_row(logic [ior_pkg::DimW-1:0] w,
                                       logic [ior_pkg::DimW-1:0] h,
                                       logic [ior_pkg::OrientW-1:0] o);
    dir_row_t d;
    d = '0;
    d.kind = RowCfg;
    d.w = w;
    d.h = h;
    d.o = o;
    return d;
  endfunction

  // Random request; reads only touch written entries or indexes past the image
  function automatic ior_pkg::req_t rand_req();
    ior_pkg::req_t r;
    int unsigned   sel;
    int unsigned   total;
    total = eff_dim(width_reg, MaxW) * eff_dim(height_reg, MaxH);
    sel = $urandom_range(99);
    r.pixel_in = $urandom();
    r.out_index = ior_pkg::OutIdxW'($urandom());
    if (sel < 60 || written_q.size() == 0) begin
      r.req_type = ior_pkg::ReqWrite;
      if (sel < 3) r.pixel_in = '0;
      else if (sel < 6) r.pixel_in = '1;
    end else begin
      r.req_type = ior_pkg::ReqRead;
      if (sel < 82) begin
        r.out_index = ior_pkg::OutIdxW'(written_q[$urandom_range(written_q.size() - 1)]);
      end else if (sel < 92 && total < StoreDepth) begin
        r.out_index = ior_pkg::OutIdxW'($urandom_range(StoreDepth - 1, total));
      end
      if (r.out_index < total && !img_valid[r.out_index])
        r.out_index = ior_pkg::OutIdxW'(written_q[$urandom_range(written_q.size() - 1)]);
    end
    return r;
  endfunction

  // Present one request, wait for the handshake, then log what it must return
  task automatic put_req(input ior_pkg::req_t r, input logic chk, input ior_pkg::rsp_t want);
    int unsigned   gap;
    ior_pkg::rsp_t pred;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    predict_rotated(r, pred);
    due_rsp_q.push_back(chk ? want : pred);
    if (r.req_type == ior_pkg::ReqWrite) n_writes++;
    else n_reads++;
    if (pred.frame_done) n_frames++;
    if (pred.index_error) n_idx_err++;
  endtask

  // Drop valid and let every outstanding response drain
  task automatic wait_idle();
    req_valid <= 1'b0;
    while (due_rsp_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Write all three registers back to back; only called while idle
  task automatic write_regs(input logic [ior_pkg::DimW-1:0] w,
                            input logic [ior_pkg::DimW-1:0] h,
                            input logic [ior_pkg::OrientW-1:0] o);
    cfg_we <= 1'b1;
    cfg_idx <= ior_pkg::RegSrcWidth;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_idx <= ior_pkg::RegSrcHeight;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_idx <= ior_pkg::RegOrientation;
    cfg_wdata <= ior_pkg::CfgDataW'(o);
    @(posedge clk);
    cfg_we <= 1'b0;
    width_reg = w;
    height_reg = h;
    orient_reg = o;
    n_settings++;
  endtask

  function automatic void cmp_field(string name, logic [ior_pkg::PixW-1:0] want,
                                    logic [ior_pkg::PixW-1:0] got);
    if (got !== want) begin
      fail_cnt++;
      if (fail_cnt <= MaxReports)
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Receiver stalls
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Response checker
  always @(posedge clk) begin
    if (rst_n && rsp_valid && rsp_ready) begin
      if (due_rsp_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MaxReports)
          $display("%0t: response with none pending: expected nothing, actual %h", $time, rsp);
      end else begin
        chk_want = due_rsp_q.pop_front();
        cmp_field("pixel_out", chk_want.pixel_out, rsp.pixel_out);
        cmp_field("frame_done", ior_pkg::PixW'(chk_want.frame_done),
                  ior_pkg::PixW'(rsp.frame_done));
        cmp_field("index_error", ior_pkg::PixW'(chk_want.index_error),
                  ior_pkg::PixW'(rsp.index_error));
      end
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if (!rst_n) begin
      stuck_cyc <= 0;
    end else begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stuck_cyc <= 0;
      else stuck_cyc <= stuck_cyc + 1;
      if (stuck_cyc >= StuckLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, StuckLimit);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [ior_pkg::DimW-1:0]    w;
    logic [ior_pkg::DimW-1:0]    h;
    logic [ior_pkg::OrientW-1:0] o;

    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_wdata <= '0;
    req_valid <= 1'b0;
    req <= '0;
    send_idle_pct = 0;
    stall_pct = 0;
    fail_cnt = 0;
    n_writes = 0;
    n_reads = 0;
    n_frames = 0;
    n_idx_err = 0;
    n_settings = 0;
    col_q = 0;
    row_q = 0;
    width_reg = ior_pkg::SrcWidthRst;
    height_reg = ior_pkg::SrcHeightRst;
    orient_reg = ior_pkg::OrientRst;

    // Reset defaults: 64x64 copy; two pixels in, read back
    dir_tab.push_back(req_row(ior_pkg::ReqWrite, 32'hFFFF_FFFF, 12'hFFF, 1'b1, RspQuiet));
    dir_tab.push_back(req_row(ior_pkg::ReqWrite, 32'h0000_0000, 12'h000, 1'b1, RspQuiet));
    dir_tab.push_back(req_row(ior_pkg::ReqRead, 32'hFFFF_FFFF, 12'd0, 1'b1,
                              '{pixel_out: 32'hFFFF_FFFF, frame_done: 1'b0, index_error: 1'b0}));
    dir_tab.push_back(req_row(ior_pkg::ReqRead, 32'h0, 12'd1, 1'b1, RspQuiet));
    // 2x2 at 180 degrees; counters sit past the new width, so the frame restarts
    dir_tab.push_back(cfg_row(7'd2, 7'd2, ior_pkg::OrientRot180));
    dir_tab.push_back(req_row(ior_pkg::ReqWrite, 32'h1111_0001, 12'd0, 1'b0, RspQuiet));
    dir_tab.push_back(req_row(ior_pkg::ReqWrite, 32'h2222_0002, 12'd0, 1'b0, RspQuiet));
    dir_tab.push_back(req_row(ior_pkg::ReqWrite, 32'h3333_0003, 12'd0, 1'b0, RspQuiet));
    dir_tab.push_back(req_row(ior_pkg::ReqWrite, 32'h4444_0004, 12'd0, 1'b1, RspDone));
    dir_tab.push_back(req_row(ior_pkg::ReqRead, 32'h0, 12'd0, 1'b0, RspQuiet));
    dir_tab.push_back(req_row(ior_pkg::ReqRead, 32'h0, 12'd3, 1'b0, RspQuiet));
    dir_tab.push_back(req_row(ior_pkg::ReqRead, 32'h0, 12'd4, 1'b1, RspIdxErr));
    dir_tab.push_back(req_row(ior_pkg::ReqRead, 32'h0, 12'hFFF, 1'b1, RspIdxErr));
    // 90 degrees clockwise
    dir_tab.push_back(cfg_row(7'd2, 7'd2, ior_pkg::OrientRot90Cw));
    dir_tab.push_back(req_row(ior_pkg::ReqWrite, 32'h5555_0001, 12'd0, 1'b0, RspQuiet));
    dir_tab.push_back(req_row(ior_pkg::ReqWrite, 32'h6666_0002, 12'd0, 1'b0, RspQuiet));
    dir_tab.push_back(req_row(ior_pkg::ReqWrite, 32'h7777_0003, 12'd0, 1'b0, RspQuiet));
    dir_tab.push_back(req_row(ior_pkg::ReqWrite, 32'h8888_0004, 12'd0, 1'b1, RspDone));
    dir_tab.push_back(req_row(ior_pkg::ReqRead, 32'h0, 12'd1, 1'b0, RspQuiet));
    // 90 degrees counterclockwise
    dir_tab.push_back(cfg_row(7'd2, 7'd2, ior_pkg::OrientRot90Ccw));
    dir_tab.push_back(req_row(ior_pkg::ReqWrite, 32'h9999_0001, 12'd0, 1'b0, RspQuiet));
    dir_tab.push_back(req_row(ior_pkg::ReqWrite, 32'hAAAA_0002, 12'd0, 1'b0, RspQuiet));
    dir_tab.push_back(req_row(ior_pkg::ReqWrite, 32'hBBBB_0003, 12'd0, 1'b0, RspQuiet));
    dir_tab.push_back(req_row(ior_pkg::ReqWrite, 32'hCCCC_0004, 12'd0, 1'b1, RspDone));
    dir_tab.push_back(req_row(ior_pkg::ReqRead, 32'h0, 12'd2, 1'b0, RspQuiet));
    // zero width reads as 1, oversize height saturates at 64, unknown code copies
    dir_tab.push_back(cfg_row(7'd0, 7'd127, 4'd15));
    dir_tab.push_back(req_row(ior_pkg::ReqWrite, 32'hDEAD_BEEF, 12'd0, 1'b0, RspQuiet));
    dir_tab.push_back(req_row(ior_pkg::ReqRead, 32'h0, 12'd64, 1'b1, RspIdxErr));
    dir_tab.push_back(req_row(ior_pkg::ReqRead, 32'h0, 12'd0, 1'b0, RspQuiet));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == RowCfg) begin
        wait_idle();
        write_regs(dir_tab[i].w, dir_tab[i].h, dir_tab[i].o);
      end else begin
        put_req(dir_tab[i].rq, dir_tab[i].chk, dir_tab[i].want);
      end
    end

    // Random phases: extreme sizes first, then mostly small frames
    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 58; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 58; end
        default: begin send_idle_pct = 34; stall_pct = 34; end
      endcase
      case (p)
        0: begin w = 7'd64;  h = 7'd64; o = ior_pkg::OrientRst;      end
        1: begin w = 7'd64;  h = 7'd1;  o = ior_pkg::OrientRot180;   end
        2: begin w = 7'd1;   h = 7'd64; o = ior_pkg::OrientRot90Cw;  end
        3: begin w = 7'd127; h = 7'd0;  o = ior_pkg::OrientRot90Ccw; end
        4: begin w = 7'd0;   h = 7'd2;  o = 4'd0;                    end
        5: begin w = 7'd64;  h = 7'd2;  o = 4'd15;                   end
        default: begin
          w = ($urandom_range(7) == 0) ? ior_pkg::DimW'($urandom_range(127))
                                       : ior_pkg::DimW'($urandom_range(8, 1));
          h = ($urandom_range(7) == 0) ? ior_pkg::DimW'($urandom_range(127))
                                       : ior_pkg::DimW'($urandom_range(8, 1));
          case ($urandom_range(3))
            0: o = ior_pkg::OrientRot180;
            1: o = ior_pkg::OrientRot90Cw;
            2: o = ior_pkg::OrientRot90Ccw;
            default: o = ior_pkg::OrientW'($urandom_range(15));
          endcase
        end
      endcase
      write_regs(w, h, o);
      repeat (ItemsPerPhase) put_req(rand_req(), 1'b0, RspQuiet);
    end

    wait_idle();
    $display("Covered %0d writes and %0d reads over %0d register settings;", n_writes,
             n_reads, n_settings);
    $display("%0d frames completed, %0d out-of-range reads, %0d mismatches.", n_frames,
             n_idx_err, fail_cnt);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/ior_pkg.sv
hdl/ior_frame_mem.sv
hdl/image_orientation_rotator.sv
test/image_orientation_rotator_tb.sv
